>>> hw/rtl/prc_pkg.sv
package prc_pkg;

  // Fixed field widths
  localparam int COORD_W    = 32;
  localparam int ANGLE_W    = 16;
  localparam int ANGLE_FRAC = 13;

  // CORDIC working format: Q3.30 with one guard bit above Q2.30
  localparam int WORK_FRAC  = 30;
  localparam int WORK_W     = 34;
  localparam int TAB_LEN    = 24;
  localparam int ATAN_IDX_W = 5;

  typedef logic signed [WORK_W-1:0] work_t;

  localparam work_t PI_WORK      = work_t'(64'sd3373259426);
  localparam work_t HALF_PI_WORK = work_t'(64'sd1686629713);
  localparam work_t GAIN_WORK    = work_t'(64'sd652032874);

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] x_in;
    logic signed [COORD_W-1:0] y_in;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_out;
    logic signed [COORD_W-1:0] y_out;
    logic                      clipped;
  } out_item_t;

  // atan(2^-i) in Q2.30
  function automatic work_t atan_work(input logic [ATAN_IDX_W-1:0] idx);
    work_t val;
    case (idx)
      5'd0:    val = work_t'(64'sd843314857);
      5'd1:    val = work_t'(64'sd497837829);
      5'd2:    val = work_t'(64'sd263043837);
      5'd3:    val = work_t'(64'sd133525159);
      5'd4:    val = work_t'(64'sd67021687);
      5'd5:    val = work_t'(64'sd33543516);
      5'd6:    val = work_t'(64'sd16775851);
      5'd7:    val = work_t'(64'sd8388437);
      5'd8:    val = work_t'(64'sd4194283);
      5'd9:    val = work_t'(64'sd2097149);
      5'd10:   val = work_t'(64'sd1048576);
      5'd11:   val = work_t'(64'sd524288);
      5'd12:   val = work_t'(64'sd262144);
      5'd13:   val = work_t'(64'sd131072);
      5'd14:   val = work_t'(64'sd65536);
      5'd15:   val = work_t'(64'sd32768);
      5'd16:   val = work_t'(64'sd16384);
      5'd17:   val = work_t'(64'sd8192);
      5'd18:   val = work_t'(64'sd4096);
      5'd19:   val = work_t'(64'sd2048);
      5'd20:   val = work_t'(64'sd1024);
      5'd21:   val = work_t'(64'sd512);
      5'd22:   val = work_t'(64'sd256);
      5'd23:   val = work_t'(64'sd128);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

>>> hw/rtl/point_rotation_2d.sv
// Channel  Dir  Handshake          Payload
// -------  ---  -----------------  ---------------------------------------
// in_      in   in_valid/in_ready   prc_pkg::in_item_t  (x_in, y_in Q15.16)
// out_     out  out_valid/out_ready prc_pkg::out_item_t (x_out, y_out, clipped)
// cfg_     in   cfg_valid/cfg_ready cfg_data: rotation angle, Q2.13 radians
//
// One item per cycle sustained while out_ready stays high and no angle write is
// pending or running; an item passes the input register, then the result
// register, before out_valid rises.
// An angle write starts the iterative CORDIC: one micro-rotation per cycle
// for min(CORDIC_STAGES, 24) micro-rotations, then a rounding step; in_ready
// and cfg_ready stay low until it is done.
// Reset (rst_n low, synchronous) empties the pipe and sets cos = 1.0, sin = 0.
// Each stage holds its item until the next stage can take it, so a stalled
// output does not stop items entering until the pipe is full.
module point_rotation_2d #(
  parameter int TRIG_FRAC_BITS = 16,
  parameter int CORDIC_STAGES  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  prc_pkg::in_item_t                  in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output prc_pkg::out_item_t                 out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic signed [prc_pkg::ANGLE_W-1:0] cfg_data
);

  localparam int CW = prc_pkg::COORD_W;
  localparam int TW = TRIG_FRAC_BITS + 2;
  // each product of a coordinate and a trig value, with headroom
  localparam int PW = CW + TW;
  // sum of two products plus the rounding half
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] RND_HALF = SW'(1) <<< (TRIG_FRAC_BITS - 1);
  localparam logic signed [SW-1:0] SAT_MAX  = SW'(prc_pkg::COORD_MAX);
  localparam logic signed [SW-1:0] SAT_MIN  = SW'(prc_pkg::COORD_MIN);

  logic                  trig_busy;
  logic signed [TW-1:0]  cos_val, sin_val;
  logic                  cfg_write;

  // stage 1: input register
  logic                  s1_valid_r, s1_valid_nxt;
  logic signed [CW-1:0]  s1_x_r, s1_y_r;
  logic signed [PW-1:0]  p_xc, p_ys, p_xs, p_yc;
  // stage 2: result register
  logic                  out_valid_r, out_valid_nxt;
  prc_pkg::out_item_t    out_item_r, out_item_nxt;

  logic                  rdy1, rdy2;
  logic signed [SW-1:0]  rx_sum, ry_sum, rx, ry;
  logic                  clip_x, clip_y;

  assign cfg_ready = !trig_busy;
  assign cfg_write = cfg_valid && cfg_ready;

  prc_cordic #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cfg_write),
    .angle  (cfg_data),
    .busy   (trig_busy),
    .cos_val(cos_val),
    .sin_val(sin_val)
  );

  // a stage can load when it is empty or its item moves on this cycle
  assign rdy2     = !out_valid_r || out_ready;
  assign rdy1     = !s1_valid_r || rdy2;
  // no item enters while the trig values are being recomputed
  assign in_ready = rdy1 && !trig_busy && !cfg_valid;

  // four independent signed products, coordinate x trig value
  assign p_xc = PW'(s1_x_r) * PW'(cos_val);
  assign p_ys = PW'(s1_y_r) * PW'(sin_val);
  assign p_xs = PW'(s1_x_r) * PW'(sin_val);
  assign p_yc = PW'(s1_y_r) * PW'(cos_val);

  // exact sums, round half up, then clamp to the coordinate range
  always_comb begin
    rx_sum = SW'(p_xc) - SW'(p_ys) + RND_HALF;
    ry_sum = SW'(p_xs) + SW'(p_yc) + RND_HALF;
    rx     = rx_sum >>> TRIG_FRAC_BITS;
    ry     = ry_sum >>> TRIG_FRAC_BITS;
    clip_x = (rx > SAT_MAX) || (rx < SAT_MIN);
    clip_y = (ry > SAT_MAX) || (ry < SAT_MIN);
    if (rx > SAT_MAX) begin
      out_item_nxt.x_out = prc_pkg::COORD_MAX;
    end else if (rx < SAT_MIN) begin
      out_item_nxt.x_out = prc_pkg::COORD_MIN;
    end else begin
      out_item_nxt.x_out = CW'(rx);
    end
    if (ry > SAT_MAX) begin
      out_item_nxt.y_out = prc_pkg::COORD_MAX;
    end else if (ry < SAT_MIN) begin
      out_item_nxt.y_out = prc_pkg::COORD_MIN;
    end else begin
      out_item_nxt.y_out = CW'(ry);
    end
    out_item_nxt.clipped = clip_x || clip_y;
  end

  always_comb begin
    s1_valid_nxt  = rdy1 ? (in_valid && in_ready) : s1_valid_r;
    out_valid_nxt = rdy2 ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_x_r <= in_item.x_in;
      s1_y_r <= in_item.y_in;
    end
    if (rdy2 && s1_valid_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // no item is taken while the trig unit is working
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    trig_busy |-> !(in_valid && in_ready))
    else $error("item accepted during trig update");

  // an angle write always starts the trig unit
  a_cfg_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_write |=> trig_busy)
    else $error("angle write did not start trig update");

  // a new result only appears when the input stage held an item
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result without an input item");

  // a clipped result sits at an end of the coordinate range
  a_clip_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.clipped) |->
      (out_item_r.x_out == prc_pkg::COORD_MAX || out_item_r.x_out == prc_pkg::COORD_MIN ||
       out_item_r.y_out == prc_pkg::COORD_MAX || out_item_r.y_out == prc_pkg::COORD_MIN))
    else $error("clipped flag without a saturated coordinate");

endmodule

>>> hw/rtl/prc_cordic.sv
// Iterative CORDIC: one micro-rotation per cycle, then a rounding step.
module prc_cordic #(
  parameter int TRIG_FRAC_BITS = 16,
  parameter int CORDIC_STAGES  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [prc_pkg::ANGLE_W-1:0] angle,
  output logic                              busy,
  output logic signed [TRIG_FRAC_BITS+1:0]  cos_val,
  output logic signed [TRIG_FRAC_BITS+1:0]  sin_val
);

  localparam int TW     = TRIG_FRAC_BITS + 2;
  localparam int STAGES = (CORDIC_STAGES < prc_pkg::TAB_LEN) ? CORDIC_STAGES
                                                             : prc_pkg::TAB_LEN;
  localparam int IW     = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int SH     = prc_pkg::WORK_FRAC - TRIG_FRAC_BITS;
  localparam prc_pkg::work_t RND_HALF = prc_pkg::work_t'(1) <<< (SH - 1);
  localparam prc_pkg::work_t ONE      = prc_pkg::work_t'(1) <<< TRIG_FRAC_BITS;

  typedef enum logic [1:0] {ST_IDLE, ST_ITER, ST_FINISH} state_t;

  state_t                     state_r, state_nxt;
  logic [IW-1:0]              idx_r, idx_nxt;
  prc_pkg::work_t             cx_r, cx_nxt, cy_r, cy_nxt, z_r, z_nxt;
  logic                       flip_r, flip_nxt;
  logic signed [TW-1:0]       cos_r, cos_nxt, sin_r, sin_nxt;

  prc_pkg::work_t z_load, dx, dy, atan_i, c_rnd, s_rnd;

  // rounds a Q2.30 value half up to the trig format and clamps to +-1.0
  function automatic prc_pkg::work_t trig_round(input prc_pkg::work_t w);
    prc_pkg::work_t r;
    r = (w + RND_HALF) >>> SH;
    if (r > ONE) r = ONE;
    if (r < -ONE) r = -ONE;
    return r;
  endfunction

  always_comb begin
    z_load = prc_pkg::work_t'(angle) <<< (prc_pkg::WORK_FRAC - prc_pkg::ANGLE_FRAC);
    dx     = cy_r >>> idx_r;
    dy     = cx_r >>> idx_r;
    atan_i = prc_pkg::atan_work(prc_pkg::ATAN_IDX_W'(idx_r));
    c_rnd  = trig_round(cx_r);
    s_rnd  = trig_round(cy_r);
    if (flip_r) begin
      c_rnd = -c_rnd;
      s_rnd = -s_rnd;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    z_nxt     = z_r;
    flip_nxt  = flip_r;
    cos_nxt   = cos_r;
    sin_nxt   = sin_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_ITER;
          idx_nxt   = '0;
          cx_nxt    = prc_pkg::GAIN_WORK;
          cy_nxt    = '0;
          // fold into -pi/2..pi/2, result negated at the end
          if (z_load > prc_pkg::HALF_PI_WORK) begin
            z_nxt    = z_load - prc_pkg::PI_WORK;
            flip_nxt = 1'b1;
          end else if (z_load < -prc_pkg::HALF_PI_WORK) begin
            z_nxt    = z_load + prc_pkg::PI_WORK;
            flip_nxt = 1'b1;
          end else begin
            z_nxt    = z_load;
            flip_nxt = 1'b0;
          end
        end
      end
      ST_ITER: begin
        if (!z_r[prc_pkg::WORK_W-1]) begin
          cx_nxt = cx_r - dx;
          cy_nxt = cy_r + dy;
          z_nxt  = z_r - atan_i;
        end else begin
          cx_nxt = cx_r + dx;
          cy_nxt = cy_r - dy;
          z_nxt  = z_r + atan_i;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IW'(STAGES - 1)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cos_nxt   = TW'(c_rnd);
        sin_nxt   = TW'(s_rnd);
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cos_r   <= TW'(ONE);
      sin_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cos_r   <= cos_nxt;
      sin_r   <= sin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    z_r    <= z_nxt;
    flip_r <= flip_nxt;
  end

  assign busy    = (state_r != ST_IDLE);
  assign cos_val = cos_r;
  assign sin_val = sin_r;

endmodule
